>>> rtl/rfdd_pkg.sv
// Shared types and codes for the radio frame duplicate filter with auto-ACK.
// Used by rfdd_cell, radio_frame_dedup_autoack and the testbench; depends on nothing else.
package rfdd_pkg;

  // One history entry: the sender address and its sequence number.
  typedef struct packed {
    logic [7:0] src;
    logic [7:0] seq;
  } entry_t;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEDUP_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_ACK_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_FLAG_MSK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_REQ_MSK  = 3'd5;

  // Register reset values.
  localparam logic [7:0] RST_NODE_ADDR    = 8'd0;
  localparam logic [7:0] RST_BCAST_ADDR   = 8'd255;
  localparam logic [7:0] RST_ACK_FLAG_MSK = 8'd128;
  localparam logic [7:0] RST_ACK_REQ_MSK  = 8'd64;

endpackage

>>> rtl/rfdd_cell.sv
// One cell of the duplicate history: holds one (source, sequence) entry.
// On an insert it takes its neighbor's entry; it compares its own against the probe.
// Depends on rfdd_pkg.
module rfdd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  rfdd_pkg::entry_t prev_entry,
  input  rfdd_pkg::entry_t probe,
  output rfdd_pkg::entry_t entry,
  output logic            hit
);

  rfdd_pkg::entry_t entry_r;
  rfdd_pkg::entry_t entry_nxt;

  // Shift the neighbor's entry in when a new pair enters the row.
  always_comb begin
    entry_nxt = entry_r;
    if (shift_en) begin
      entry_nxt = prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  // A cleared entry has sequence zero, which is never looked up.
  assign hit   = (entry_r == probe);
  assign entry = entry_r;

endmodule

>>> rtl/radio_frame_dedup_autoack.sv
// Top level of the radio frame duplicate filter with automatic ACK request.
// Builds the history row from rfdd_cell and uses codes and types from rfdd_pkg.
//
// For each word taken on start, the length check, the compare
// against every history cell in parallel and the insert all happen in the cycle
// of acceptance, and the result strobes on out_valid for one cycle on the next
// clock. busy never rises, so a new header may be presented every cycle; the
// receiver cannot stall and must take each result in the cycle it is shown. The
// history is a row of CACHE_ENTRIES cells; a new pair enters the first cell and
// every entry moves one cell on, so the oldest pair falls off the end.
module radio_frame_dedup_autoack #(
  parameter int unsigned MAX_PAYLOAD   = 61,
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port.
  input  logic                           cfg_we,
  input  logic [rfdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata,
  // Input channel.
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     in_frame_length,
  input  logic [7:0]                     in_dest_address,
  input  logic [7:0]                     in_source_byte,
  input  logic [7:0]                     in_sequence_byte,
  input  logic [7:0]                     in_flags_byte,
  input  logic                           in_awaiting_ack,
  // Result channel.
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [7:0]                     out_frame_source,
  output logic [7:0]                     out_frame_sequence,
  output logic [7:0]                     out_frame_flags,
  output logic                           out_send_ack,
  output logic [7:0]                     out_ack_source
);

  localparam logic [8:0] LEN_MAX = 9'(MAX_PAYLOAD + 1);

  // Configuration registers.
  logic [7:0] node_addr_r;
  logic [7:0] bcast_addr_r;
  logic       dedup_en_r;
  logic       auto_ack_en_r;
  logic [7:0] ack_flag_msk_r;
  logic [7:0] ack_req_msk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r    <= rfdd_pkg::RST_NODE_ADDR;
      bcast_addr_r   <= rfdd_pkg::RST_BCAST_ADDR;
      dedup_en_r     <= 1'b1;
      auto_ack_en_r  <= 1'b1;
      ack_flag_msk_r <= rfdd_pkg::RST_ACK_FLAG_MSK;
      ack_req_msk_r  <= rfdd_pkg::RST_ACK_REQ_MSK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfdd_pkg::REG_NODE_ADDR:    node_addr_r    <= cfg_wdata;
        rfdd_pkg::REG_BCAST_ADDR:   bcast_addr_r   <= cfg_wdata;
        rfdd_pkg::REG_DEDUP_EN:     dedup_en_r     <= cfg_wdata[0];
        rfdd_pkg::REG_AUTO_ACK_EN:  auto_ack_en_r  <= cfg_wdata[0];
        rfdd_pkg::REG_ACK_FLAG_MSK: ack_flag_msk_r <= cfg_wdata;
        rfdd_pkg::REG_ACK_REQ_MSK:  ack_req_msk_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The block takes a header in every cycle.
  logic in_acc;
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // Header decode: length check and the effective sequence and flags.
  logic       len_ok;
  logic [7:0] eff_seq;
  logic [7:0] eff_flags;
  logic       lookup;
  logic       dup;
  logic       insert;
  logic       ack_req;

  assign len_ok    = (in_frame_length >= 8'd2) && ({1'b0, in_frame_length} <= LEN_MAX);
  assign eff_seq   = (in_frame_length >= 8'd3) ? in_sequence_byte : 8'd0;
  assign eff_flags = (in_frame_length >= 8'd4) ? in_flags_byte : 8'd0;
  assign lookup    = dedup_en_r && ((eff_flags & ack_flag_msk_r) == 8'd0) &&
                     (eff_seq != 8'd0);

  // History row: each cell takes its neighbor's entry on an insert.
  rfdd_pkg::entry_t probe;
  rfdd_pkg::entry_t cell_entry [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] cell_hit;

  assign probe.src = in_source_byte;
  assign probe.seq = eff_seq;

  for (genvar gi = 0; gi < CACHE_ENTRIES; gi++) begin : g_cell
    rfdd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (insert),
      .prev_entry ((gi == 0) ? probe : cell_entry[(gi == 0) ? 0 : gi - 1]),
      .probe      (probe),
      .entry      (cell_entry[gi]),
      .hit        (cell_hit[gi])
    );
  end

  assign dup     = lookup && (|cell_hit);
  assign insert  = in_acc && len_ok && lookup && !dup;
  assign ack_req = auto_ack_en_r && !in_awaiting_ack &&
                   (in_dest_address != bcast_addr_r) &&
                   ((eff_flags & ack_req_msk_r) != 8'd0);

  // Result register.
  logic       out_valid_r;
  logic [1:0] status_r;
  logic [7:0] src_r;
  logic [7:0] seq_r;
  logic [7:0] flags_r;
  logic       send_ack_r;
  logic [7:0] ack_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!len_ok) begin
        status_r   <= rfdd_pkg::ST_BAD_LEN;
        src_r      <= 8'd0;
        seq_r      <= 8'd0;
        flags_r    <= 8'd0;
        send_ack_r <= 1'b0;
        ack_src_r  <= 8'd0;
      end else begin
        status_r   <= dup ? rfdd_pkg::ST_DUPLICATE : rfdd_pkg::ST_ACCEPTED;
        src_r      <= in_source_byte;
        seq_r      <= eff_seq;
        flags_r    <= eff_flags;
        send_ack_r <= !dup && ack_req;
        ack_src_r  <= (!dup && ack_req) ? node_addr_r : 8'd0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_frame_source   = src_r;
  assign out_frame_sequence = seq_r;
  assign out_frame_flags    = flags_r;
  assign out_send_ack       = send_ack_r;
  assign out_ack_source     = ack_src_r;

  // A result word follows exactly one accepted header.
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc))
    else $error("result word without an accepted header");

  // Only an accepted frame may request an ACK.
  a_ack_only_when_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_ack) |-> (out_status == rfdd_pkg::ST_ACCEPTED))
    else $error("ACK requested for a rejected frame");

  // The ACK source is this node's address whenever an ACK is requested.
  a_ack_source_node: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_ack) |-> (out_ack_source == $past(node_addr_r)))
    else $error("ACK source differs from node address");

  // A new pair enters the history only for a header with a good length and a nonzero sequence.
  a_insert_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    insert |-> (len_ok && eff_seq != 8'd0))
    else $error("history written for a bad or unsequenced header");

endmodule

>>> sim/tb.sv
// Self-checking testbench for radio_frame_dedup_autoack: frame headers, register writes and
// checks of every status word against an in-bench model of the filter and its history.
// Depends on rfdd_pkg and the radio_frame_dedup_autoack RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_PAYLOAD   = 61;
  localparam int unsigned CACHE_DEPTH   = 8;
  localparam int unsigned CACHE_IDX_W   = $clog2(CACHE_DEPTH);
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_FRAMES  = 105;
  localparam int unsigned RECENT_DEPTH  = 12;

  // One received frame header as the sender presents it.
  typedef struct {
    logic [7:0] len;
    logic [7:0] dest;
    logic [7:0] src;
    logic [7:0] seq;
    logic [7:0] flags;
    logic       awaiting;
    int         gap;
  } rx_frame_t;

  // One status word as the filter reports it.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] src;
    logic [7:0] seq;
    logic [7:0] flags;
    logic       ack;
    logic [7:0] ack_src;
  } verdict_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [rfdd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_frame_length = 8'd0;
  logic [7:0] in_dest_address = 8'd0;
  logic [7:0] in_source_byte = 8'd0;
  logic [7:0] in_sequence_byte = 8'd0;
  logic [7:0] in_flags_byte = 8'd0;
  logic       in_awaiting_ack = 1'b0;
  logic       out_valid;
  logic [1:0] out_status;
  logic [7:0] out_frame_source;
  logic [7:0] out_frame_sequence;
  logic [7:0] out_frame_flags;
  logic       out_send_ack;
  logic [7:0] out_ack_source;

  // Headers still to be sent, and the status words the filter owes us.
  rx_frame_t  rx_frames[$];
  verdict_t   predicted_verdicts[$];
  logic [15:0] recent_pairs[$];

  // Our copy of the registers and of the duplicate history.
  logic [7:0] reg_node_addr    = rfdd_pkg::RST_NODE_ADDR;
  logic [7:0] reg_bcast_addr   = rfdd_pkg::RST_BCAST_ADDR;
  logic       reg_dedup_en     = 1'b1;
  logic       reg_auto_ack_en  = 1'b1;
  logic [7:0] reg_ack_flag_msk = rfdd_pkg::RST_ACK_FLAG_MSK;
  logic [7:0] reg_ack_req_msk  = rfdd_pkg::RST_ACK_REQ_MSK;
  logic [7:0] seen_src[CACHE_DEPTH];
  logic [7:0] seen_seq[CACHE_DEPTH];
  logic [CACHE_IDX_W-1:0] fill_ptr = '0;

  logic        word_taken = 1'b0;
  int          gap_left = 0;
  logic        burst_mode = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  radio_frame_dedup_autoack #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .CACHE_ENTRIES(CACHE_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .in_frame_length   (in_frame_length),
    .in_dest_address   (in_dest_address),
    .in_source_byte    (in_source_byte),
    .in_sequence_byte  (in_sequence_byte),
    .in_flags_byte     (in_flags_byte),
    .in_awaiting_ack   (in_awaiting_ack),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_frame_source  (out_frame_source),
    .out_frame_sequence(out_frame_sequence),
    .out_frame_flags   (out_frame_flags),
    .out_send_ack      (out_send_ack),
    .out_ack_source    (out_ack_source)
  );

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // History starts cleared, as the filter's does after reset.
  initial begin
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      seen_src[i] = 8'd0;
      seen_seq[i] = 8'd0;
    end
  end

  // Works out the status word of one header and updates the history as the filter would.
  function automatic verdict_t filter_frame(rx_frame_t f);
    verdict_t   v;
    logic [7:0] seq_eff;
    logic [7:0] flags_eff;
    logic       hit;
    v = '0;
    if (f.len < 2 || f.len > MAX_PAYLOAD + 1) begin
      v.status = rfdd_pkg::ST_BAD_LEN;
      return v;
    end
    seq_eff   = (f.len < 3) ? 8'd0 : f.seq;
    flags_eff = (f.len < 4) ? 8'd0 : f.flags;
    v.status  = rfdd_pkg::ST_ACCEPTED;
    v.src     = f.src;
    v.seq     = seq_eff;
    v.flags   = flags_eff;
    // ACK frames and sequence zero bypass the history entirely.
    if (reg_dedup_en && (flags_eff & reg_ack_flag_msk) == 8'd0 && seq_eff != 8'd0) begin
      hit = 1'b0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (seen_src[i] == f.src && seen_seq[i] == seq_eff) hit = 1'b1;
      end
      if (hit) begin
        v.status = rfdd_pkg::ST_DUPLICATE;
        return v;
      end
      seen_src[fill_ptr] = f.src;
      seen_seq[fill_ptr] = seq_eff;
      fill_ptr = (int'(fill_ptr) == CACHE_DEPTH - 1) ? '0 : fill_ptr + 1'b1;
    end
    if (reg_auto_ack_en && !f.awaiting && f.dest != reg_bcast_addr &&
        (flags_eff & reg_ack_req_msk) != 8'd0) begin
      v.ack     = 1'b1;
      v.ack_src = reg_node_addr;
    end
    return v;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: checks each status word, tracks register writes and predicts each taken header.
  always @(posedge clk) begin : monitor
    verdict_t  want;
    rx_frame_t taken;
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (predicted_verdicts.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual status %0h src %0h seq %0h",
                   $time, out_status, out_frame_source, out_frame_sequence);
          error_count++;
        end else begin
          want = predicted_verdicts.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("frame_source", 32'(want.src), 32'(out_frame_source));
          check_field("frame_sequence", 32'(want.seq), 32'(out_frame_sequence));
          check_field("frame_flags", 32'(want.flags), 32'(out_frame_flags));
          check_field("send_ack", 32'(want.ack), 32'(out_send_ack));
          check_field("ack_source", 32'(want.ack_src), 32'(out_ack_source));
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          rfdd_pkg::REG_NODE_ADDR:    reg_node_addr    = cfg_wdata;
          rfdd_pkg::REG_BCAST_ADDR:   reg_bcast_addr   = cfg_wdata;
          rfdd_pkg::REG_DEDUP_EN:     reg_dedup_en     = cfg_wdata[0];
          rfdd_pkg::REG_AUTO_ACK_EN:  reg_auto_ack_en  = cfg_wdata[0];
          rfdd_pkg::REG_ACK_FLAG_MSK: reg_ack_flag_msk = cfg_wdata;
          rfdd_pkg::REG_ACK_REQ_MSK:  reg_ack_req_msk  = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        taken.len      = in_frame_length;
        taken.dest     = in_dest_address;
        taken.src      = in_source_byte;
        taken.seq      = in_sequence_byte;
        taken.flags    = in_flags_byte;
        taken.awaiting = in_awaiting_ack;
        taken.gap      = 0;
        predicted_verdicts.push_back(filter_frame(taken));
      end
      word_taken <= start && !busy;
    end
  end

  // Driver: presents queued headers on the falling edge, holding each until it is taken.
  always @(negedge clk) begin : driver
    rx_frame_t nxt;
    logic      drive_start;
    drive_start = start;
    if (!start || word_taken) begin
      drive_start = 1'b0;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (rx_frames.size() > 0) begin
        nxt = rx_frames.pop_front();
        in_frame_length  <= nxt.len;
        in_dest_address  <= nxt.dest;
        in_source_byte   <= nxt.src;
        in_sequence_byte <= nxt.seq;
        in_flags_byte    <= nxt.flags;
        in_awaiting_ack  <= nxt.awaiting;
        drive_start = 1'b1;
        gap_left = nxt.gap;
      end
    end
    start <= drive_start;
  end

  // Run time limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("radio_frame_dedup_autoack verification failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all in burst mode.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_frame(input logic [7:0] len, input logic [7:0] dest,
                            input logic [7:0] src, input logic [7:0] seq,
                            input logic [7:0] flags, input logic awaiting);
    rx_frame_t f;
    f.len      = len;
    f.dest     = dest;
    f.src      = src;
    f.seq      = seq;
    f.flags    = flags;
    f.awaiting = awaiting;
    f.gap      = pick_gap();
    rx_frames.push_back(f);
  endtask

  // Random header drawn from small address and sequence pools so that duplicates,
  // evictions and repeats of recent pairs are common; a few lengths are bad.
  task automatic push_random_frame();
    int          r;
    logic [7:0]  len;
    logic [7:0]  dest;
    logic [7:0]  src;
    logic [7:0]  seq;
    logic [7:0]  flags;
    logic [15:0] pair;
    r = $urandom_range(0, 99);
    if (r < 3) len = 8'($urandom_range(0, 1));
    else if (r < 8) len = 8'($urandom_range(MAX_PAYLOAD + 2, 255));
    else if (r < 15) len = 8'($urandom_range(2, 3));
    else len = 8'($urandom_range(4, MAX_PAYLOAD + 1));

    r = $urandom_range(0, 99);
    if (r < 30 && recent_pairs.size() > 0) begin
      pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
      src  = pair[15:8];
      seq  = pair[7:0];
    end else begin
      src = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 15) seq = 8'd0;
      else if (r < 70) seq = 8'($urandom_range(1, 4));
      else seq = 8'($urandom_range(0, 255));
    end
    recent_pairs.push_back({src, seq});
    if (recent_pairs.size() > RECENT_DEPTH) void'(recent_pairs.pop_front());

    r = $urandom_range(0, 99);
    if (r < 35) flags = 8'd0;
    else if (r < 55) flags = 8'd1 << $urandom_range(0, 7);
    else if (r < 70) flags = reg_ack_req_msk;
    else if (r < 80) flags = reg_ack_flag_msk;
    else flags = 8'($urandom_range(0, 255));

    r = $urandom_range(0, 99);
    if (r < 15) dest = reg_bcast_addr;
    else if (r < 25) dest = reg_node_addr;
    else dest = 8'($urandom_range(0, 255));

    push_frame(len, dest, src, seq, flags, $urandom_range(0, 99) < 20);
  endtask

  task automatic write_reg(input logic [rfdd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_setup(input logic [7:0] node, input logic [7:0] bcast,
                             input logic [7:0] dedup, input logic [7:0] auto_ack,
                             input logic [7:0] flag_msk, input logic [7:0] req_msk);
    write_reg(rfdd_pkg::REG_NODE_ADDR, node);
    write_reg(rfdd_pkg::REG_BCAST_ADDR, bcast);
    write_reg(rfdd_pkg::REG_DEDUP_EN, dedup);
    write_reg(rfdd_pkg::REG_AUTO_ACK_EN, auto_ack);
    write_reg(rfdd_pkg::REG_ACK_FLAG_MSK, flag_msk);
    write_reg(rfdd_pkg::REG_ACK_REQ_MSK, req_msk);
  endtask

  // Waits until the sender drains and every owed word has arrived.
  task automatic wait_link_quiet();
    while (rx_frames.size() != 0 || start || predicted_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Length limits: too short, too long, and the short forms that drop sequence and flags.
    push_frame(8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_frame(8'd1, 8'h01, 8'h02, 8'h03, 8'h40, 1'b0);
    push_frame(8'(MAX_PAYLOAD + 2), 8'h01, 8'h02, 8'h03, 8'h40, 1'b0);
    push_frame(8'd255, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_frame(8'd2, 8'h10, 8'h11, 8'hFF, 8'hFF, 1'b0);
    push_frame(8'd3, 8'h10, 8'h11, 8'h22, 8'hFF, 1'b0);
    // Same pair again is a duplicate, even at the longest good length with an ACK request.
    push_frame(8'd3, 8'h10, 8'h11, 8'h22, 8'h00, 1'b0);
    push_frame(8'(MAX_PAYLOAD + 1), 8'h10, 8'h11, 8'h22, 8'h40, 1'b0);
    // Sequence zero never hits the cleared history.
    push_frame(8'd4, 8'h01, 8'h00, 8'h00, 8'h40, 1'b0);
    push_frame(8'd4, 8'h01, 8'h00, 8'h00, 8'h40, 1'b0);
    // An ACK frame skips the history check.
    push_frame(8'd4, 8'h01, 8'h11, 8'h22, 8'hC0, 1'b0);
    // Broadcast and awaiting-ACK both suppress the ACK request.
    push_frame(8'd4, 8'hFF, 8'h30, 8'h01, 8'h40, 1'b0);
    push_frame(8'd4, 8'h05, 8'h31, 8'h01, 8'h40, 1'b1);
    push_frame(8'd4, 8'h05, 8'h31, 8'h01, 8'h40, 1'b0);
    push_frame(8'd20, 8'hFE, 8'hFF, 8'hFF, 8'h7F, 1'b0);
    // Fill the history so the oldest pair is evicted, then probe old and recent pairs.
    for (int i = 0; i < 5; i++) push_frame(8'd4, 8'h02, 8'(8'h40 + i), 8'h05, 8'h00, 1'b0);
    push_frame(8'd4, 8'h02, 8'h11, 8'h22, 8'h00, 1'b0);
    push_frame(8'd4, 8'h02, 8'hFF, 8'hFF, 8'h00, 1'b0);
    for (int n = 0; n < PHASE_FRAMES; n++) push_random_frame();
    wait_link_quiet();

    // Further register settings, extremes among them; the last phase runs without gaps.
    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: apply_setup(8'hA5, 8'h00, 8'h01, 8'h01, 8'h80, 8'h40);
        2: apply_setup(8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'hFF);
        3: apply_setup(8'h00, 8'h7E, 8'h01, 8'h00, 8'hFF, 8'h00);
        4: apply_setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'd1 << $urandom_range(0, 7), 8'($urandom_range(0, 255)));
        default: apply_setup(8'h3C, 8'hFF, 8'hFE, 8'h01, 8'h01, 8'h80);
      endcase
      burst_mode = (p == 5);
      for (int n = 0; n < PHASE_FRAMES; n++) push_random_frame();
      wait_link_quiet();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("radio_frame_dedup_autoack verification clean");
    end else begin
      $display("radio_frame_dedup_autoack verification failed");
    end
    $finish;
  end

endmodule

>>> radio_frame_dedup_autoack.f
rtl/rfdd_pkg.sv
rtl/rfdd_cell.sv
rtl/radio_frame_dedup_autoack.sv
sim/tb.sv
